@@ rtl/rstally_pkg.sv @@
// Shared types, sizes and helpers of the residue substitution tally.
package rstally_pkg;

  localparam int unsigned ALPHABET_SIZE = 20;
  localparam int unsigned COUNT_BITS    = 32;
  localparam int unsigned CELLS         = ALPHABET_SIZE * ALPHABET_SIZE;
  localparam int unsigned CELL_W        = $clog2(CELLS);
  localparam int unsigned CODE_W        = $clog2(ALPHABET_SIZE);
  localparam int unsigned RES_W         = 8;
  localparam int unsigned OUT_W         = 32;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [CELL_W-1:0]     cell_t;
  typedef logic [RES_W-1:0]      residue_t;

  localparam count_t COUNT_MAX = '1;

  typedef enum logic {
    MODE_COUNT = 1'b0,
    MODE_READ  = 1'b1
  } mode_e;

  typedef struct packed {
    logic             canon;
    logic [OUT_W-1:0] count;
  } result_t;

  function automatic logic is_canon(residue_t code);
    return code < RES_W'(ALPHABET_SIZE);
  endfunction

  function automatic cell_t cell_index(residue_t a, residue_t b);
    cell_t row;
    cell_t col;
    row = cell_t'(a[CODE_W-1:0]);
    col = cell_t'(b[CODE_W-1:0]);
    return cell_t'(row * cell_t'(ALPHABET_SIZE)) + col;
  endfunction

  function automatic logic [OUT_W-1:0] clip_count(count_t v);
    logic [63:0] w;
    w = 64'(v);
    return (|w[63:OUT_W]) ? '1 : w[OUT_W-1:0];
  endfunction

endpackage

@@ rtl/rstally_outq.sv @@
// Two-entry result queue between the tally update stage and the output channel.
module rstally_outq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  rstally_pkg::result_t  push_data_i,
  input  logic                  pop_i,
  output rstally_pkg::result_t  head_o,
  output logic                  valid_o,
  output logic [1:0]            cnt_o
);

  rstally_pkg::result_t ent_q [2];
  logic                 wptr_q, wptr_d;
  logic                 rptr_q, rptr_d;
  logic [1:0]           cnt_q, cnt_d;

  always_comb begin
    wptr_d = wptr_q ^ push_i;
    rptr_d = rptr_q ^ pop_i;
    cnt_d  = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wptr_q] <= push_data_i;
    end
  end

  assign head_o  = ent_q[rptr_q];
  assign valid_o = (cnt_q != 2'd0);
  assign cnt_o   = cnt_q;

endmodule

@@ rtl/residue_substitution_tally_top.sv @@
// Top level of the residue substitution tally: count table memory and update stage.
//
// Input beats carry one residue pair: tuser is the mode (0 count, 1 read and
// clear), tdata holds residue_a in [7:0] and residue_b in [15:8]. A count beat
// adds one to the table entry of the pair, saturating, and gives no result; a
// pair with a code at or above the alphabet size is dropped. A read beat gives
// one result beat: tdata is the entry's count clipped to 32 bits, tuser is the
// canonical flag; the entry is cleared, a non-canonical read returns zero.
// Throughput is one beat per cycle while s_axis_tready is high: the table sits in
// one single-port-write memory with a registered read, and a back-to-back update
// of the same entry is forwarded from the write-back stage. A read result passes
// the update stage register and the result queue before it reaches the output.
// A two-entry result queue absorbs a stalled receiver; outside the clearing pass,
// s_axis_tready drops only when the queue could overflow. After reset a clearing
// pass zeroes all CELLS (400) entries, one entry per cycle; s_axis_tready stays low.
module residue_substitution_tally_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] residue_a, [15:8] residue_b
  input  logic        s_axis_tuser,   // [0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] pair_count
  output logic        m_axis_tuser    // [0] pair_is_canonical
);

  rstally_pkg::count_t  mem_q [rstally_pkg::CELLS];
  rstally_pkg::count_t  rd_data_q;

  logic                 clr_busy_q;
  rstally_pkg::cell_t   clr_cnt_q;

  logic                 s1_vld_q;
  rstally_pkg::mode_e   s1_mode_q;
  logic                 s1_canon_q;
  rstally_pkg::cell_t   s1_cell_q;

  logic                 fwd_q, fwd_d;
  rstally_pkg::count_t  fwd_data_q;

  rstally_pkg::residue_t in_a, in_b;
  logic                 in_canon;
  rstally_pkg::cell_t   in_cell;
  logic                 in_acc;

  rstally_pkg::count_t  cur, upd;
  logic                 wr_en;
  rstally_pkg::cell_t   wr_addr;
  rstally_pkg::count_t  wr_data;

  logic                 q_push, q_pop, s1_rd;
  logic [1:0]           q_cnt;
  logic [2:0]           occ;
  rstally_pkg::result_t q_push_data, q_head;

  assign in_a     = s_axis_tdata[7:0];
  assign in_b     = s_axis_tdata[15:8];
  assign in_canon = rstally_pkg::is_canon(in_a) && rstally_pkg::is_canon(in_b);
  assign in_cell  = in_canon ? rstally_pkg::cell_index(in_a, in_b) : '0;
  assign in_acc   = s_axis_tvalid && s_axis_tready;

  always_comb begin
    cur = fwd_q ? fwd_data_q : rd_data_q;
    if (s1_mode_q == rstally_pkg::MODE_READ) begin
      upd = '0;
    end else begin
      upd = (cur == rstally_pkg::COUNT_MAX) ? cur : cur + rstally_pkg::count_t'(1);
    end
    if (clr_busy_q) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt_q;
      wr_data = '0;
    end else begin
      wr_en   = s1_vld_q && s1_canon_q;
      wr_addr = s1_cell_q;
      wr_data = upd;
    end
    fwd_d = in_acc && s1_vld_q && s1_canon_q && in_canon && (in_cell == s1_cell_q);
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_data_q <= mem_q[in_cell];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
      s1_vld_q   <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      if (clr_busy_q) begin
        clr_cnt_q <= clr_cnt_q + rstally_pkg::cell_t'(1);
        if (clr_cnt_q == rstally_pkg::cell_t'(rstally_pkg::CELLS - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
      s1_vld_q <= in_acc;
      fwd_q    <= fwd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_mode_q  <= rstally_pkg::mode_e'(s_axis_tuser);
      s1_canon_q <= in_canon;
      s1_cell_q  <= in_cell;
    end
    if (fwd_d) begin
      fwd_data_q <= wr_data;
    end
  end

  assign s1_rd  = s1_vld_q && (s1_mode_q == rstally_pkg::MODE_READ);
  assign q_push = s1_rd;
  assign q_pop  = m_axis_tvalid && m_axis_tready;
  assign occ    = 3'(q_cnt) + 3'(s1_rd) - 3'(q_pop);
  assign s_axis_tready = !clr_busy_q && (occ <= 3'd1);

  always_comb begin
    q_push_data.canon = s1_canon_q;
    q_push_data.count = s1_canon_q ? rstally_pkg::clip_count(cur) : '0;
  end

  rstally_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .pop_i       (q_pop),
    .head_o      (q_head),
    .valid_o     (m_axis_tvalid),
    .cnt_o       (q_cnt)
  );

  assign m_axis_tdata = q_head.count;
  assign m_axis_tuser = q_head.canon;

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !s_axis_tready)
    else $error("input beat taken during clearing pass");

  a_noncanon_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("non-canonical result carries a nonzero count");

  a_queue_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_push && !q_pop) |-> (q_cnt != 2'd2))
    else $error("result queue overflow");

  a_fwd_follows_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> (s1_vld_q && $past(wr_en) && ($past(wr_addr) == s1_cell_q)))
    else $error("forwarded data does not match the previous write-back");

endmodule
